### hw/rtl/radio_rx_fifo_deframer_unit_macros.svh
// Assertion macros used by the receive FIFO deframer top level.
// Each use takes a label, the clock, the active-low reset and two expressions.
// No dependencies.
`ifndef RADIO_RX_FIFO_DEFRAMER_UNIT_MACROS_SVH
`define RADIO_RX_FIFO_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define RRFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed: next-cycle implication");

`endif

### hw/rtl/rrfd_pkg.sv
// Package for the receive FIFO deframer: codes, parser phases, queue word and status types.
// No dependencies; the front end, queue, back end and top level import it.
package rrfd_pkg;

    localparam logic [7:0] FRAME_OVERHEAD      = 8'd3;
    localparam logic [7:0] PAYLOAD_LIMIT_RESET = 8'd120;
    localparam int unsigned FLAG_SYNC_BIT   = 0;
    localparam int unsigned FLAG_NOSYNC_BIT = 1;

    // Register indexes on the configuration port.
    localparam logic REG_MAX_PAYLOAD_LEN = 1'b0;
    localparam logic REG_IS_MASTER       = 1'b1;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_PAYLOAD,
        PH_RSSI,
        PH_LQI,
        PH_DISCARD
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_STOP   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REASON_NONE      = 3'd0,
        REASON_TOO_LONG  = 3'd1,
        REASON_UNDERFLOW = 3'd2,
        REASON_EMPTY     = 3'd3,
        REASON_BAD_CRC   = 3'd4
    } reason_t;

    typedef enum logic [1:0] {
        CLASS_DATA   = 2'd0,
        CLASS_SYNC   = 2'd1,
        CLASS_NOSYNC = 2'd2
    } pkt_class_t;

    // One classified result on its way from the parser to the output stage.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        reason_t    reason;
        logic [7:0] pkt_len;
        pkt_class_t pkt_class;
        logic [7:0] rssi;
        logic [6:0] lqi;
        logic [31:0] stamp;
        logic [31:0] now_time;
        logic       sync_valid;
        logic       sync_request;
    } rrfd_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hw/rtl/rrfd_if.sv
// Stream interfaces of the receive FIFO deframer: input byte words and result words.
// Valid/ready handshake; no dependencies.
interface rrfd_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic        batch_start;
    logic [7:0]  batch_bytes;
    logic [31:0] now_time;

    modport source (output valid, output rx_byte, output batch_start, output batch_bytes,
                    output now_time, input ready);
    modport sink   (input valid, input rx_byte, input batch_start, input batch_bytes,
                    input now_time, output ready);
endinterface

interface rrfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic [2:0]         stop_reason;
    logic [7:0]         pkt_len;
    logic [1:0]         pkt_class;
    logic signed [7:0]  rssi;
    logic [6:0]         lqi;
    logic signed [31:0] sync_offset;
    logic               sync_valid;
    logic               sync_request;
    logic               last;

    modport source (output valid, output kind, output out_byte, output stop_reason,
                    output pkt_len, output pkt_class, output rssi, output lqi,
                    output sync_offset, output sync_valid, output sync_request,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input stop_reason,
                    input pkt_len, input pkt_class, input rssi, input lqi,
                    input sync_offset, input sync_valid, input sync_request,
                    input last, output ready);
endinterface

### hw/rtl/rrfd_front.sv
// Parser front end: accepts FIFO bytes, tracks the packet phase and classifies each byte.
// Depends on rrfd_pkg and rrfd_in_if; pushes classified words into rrfd_queue.
module rrfd_front
    import rrfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rrfd_in_if.sink       in_ch,
    input  logic [7:0]    max_payload_len,
    input  logic          is_master,
    input  q_status_t     q_status,
    output logic          push,
    output rrfd_entry_t   push_data
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [7:0]  cur_len_reg, cur_len_next;
    logic [7:0]  byte_pos_reg, byte_pos_next;
    logic [7:0]  flag_byte_reg, flag_byte_next;
    logic [7:0]  rssi_hold_reg, rssi_hold_next;
    logic [31:0] stamp_acc_reg, stamp_acc_next;

    logic        take;
    logic [7:0]  b;
    phase_t      eff_phase;
    logic [7:0]  eff_left;
    logic [7:0]  left_dec;
    logic [7:0]  pos_inc;
    logic [1:0]  lane;

    assign in_ch.ready = !q_status.full;
    assign take        = in_ch.valid && in_ch.ready;
    assign b           = in_ch.rx_byte;
    assign eff_phase   = in_ch.batch_start ? PH_LEN : phase_reg;
    assign eff_left    = in_ch.batch_start ? in_ch.batch_bytes : bytes_left_reg;
    assign left_dec    = (eff_left != 8'd0) ? eff_left - 8'd1 : eff_left;
    assign pos_inc     = byte_pos_reg + 8'd1;
    assign lane        = 2'(byte_pos_reg[1:0] - 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            bytes_left_reg <= 8'd0;
            cur_len_reg    <= 8'd0;
            byte_pos_reg   <= 8'd0;
            flag_byte_reg  <= 8'd0;
            rssi_hold_reg  <= 8'd0;
            stamp_acc_reg  <= 32'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            cur_len_reg    <= cur_len_next;
            byte_pos_reg   <= byte_pos_next;
            flag_byte_reg  <= flag_byte_next;
            rssi_hold_reg  <= rssi_hold_next;
            stamp_acc_reg  <= stamp_acc_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        cur_len_next    = cur_len_reg;
        byte_pos_next   = byte_pos_reg;
        flag_byte_next  = flag_byte_reg;
        rssi_hold_next  = rssi_hold_reg;
        stamp_acc_next  = stamp_acc_reg;
        push            = 1'b0;
        push_data       = '0;
        push_data.kind      = KIND_BYTE;
        push_data.reason    = REASON_NONE;
        push_data.pkt_class = CLASS_DATA;
        push_data.pkt_len   = cur_len_reg;

        if (take)
        begin
            if (in_ch.batch_start)
            begin
                bytes_left_next = in_ch.batch_bytes;
                phase_next      = PH_LEN;
            end

            unique case (eff_phase)
                PH_LEN:
                begin
                    if (eff_left <= FRAME_OVERHEAD)
                    begin
                        // Too few bytes left for a packet: drop the rest silently.
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        cur_len_next      = b;
                        push_data.pkt_len = b;
                        push_data.kind    = KIND_STOP;
                        priority if (b > max_payload_len)
                        begin
                            phase_next       = PH_DISCARD;
                            push             = 1'b1;
                            push_data.reason = REASON_TOO_LONG;
                        end
                        else if (b > eff_left - FRAME_OVERHEAD)
                        begin
                            phase_next       = PH_DISCARD;
                            push             = 1'b1;
                            push_data.reason = REASON_UNDERFLOW;
                        end
                        else if (b == 8'd0)
                        begin
                            phase_next       = PH_DISCARD;
                            push             = 1'b1;
                            push_data.reason = REASON_EMPTY;
                        end
                        else
                        begin
                            bytes_left_next = eff_left - 8'd1;
                            byte_pos_next   = 8'd0;
                            flag_byte_next  = 8'd0;
                            stamp_acc_next  = 32'd0;
                            rssi_hold_next  = 8'd0;
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                end

                PH_PAYLOAD:
                begin
                    // First payload byte is the flag byte, the next four the timestamp.
                    if (byte_pos_reg == 8'd0)
                    begin
                        flag_byte_next = b;
                    end
                    else if (byte_pos_reg <= 8'd4)
                    begin
                        stamp_acc_next = stamp_acc_reg | ({24'd0, b} << {lane, 3'b000});
                    end
                    byte_pos_next   = pos_inc;
                    bytes_left_next = left_dec;
                    if (pos_inc >= cur_len_reg)
                    begin
                        phase_next = PH_RSSI;
                    end
                    push               = 1'b1;
                    push_data.kind     = KIND_BYTE;
                    push_data.out_byte = b;
                end

                PH_RSSI:
                begin
                    rssi_hold_next  = b;
                    bytes_left_next = left_dec;
                    phase_next      = PH_LQI;
                end

                PH_LQI:
                begin
                    bytes_left_next = left_dec;
                    push            = 1'b1;
                    push_data.rssi  = rssi_hold_reg;
                    push_data.lqi   = b[6:0];
                    if (!b[7])
                    begin
                        phase_next       = PH_DISCARD;
                        push_data.kind   = KIND_STOP;
                        push_data.reason = REASON_BAD_CRC;
                    end
                    else
                    begin
                        push_data.kind = KIND_ACCEPT;
                        priority if (flag_byte_reg[FLAG_SYNC_BIT])
                        begin
                            push_data.pkt_class  = CLASS_SYNC;
                            push_data.sync_valid = !is_master;
                            push_data.stamp      = stamp_acc_reg;
                            push_data.now_time   = in_ch.now_time;
                        end
                        else if (flag_byte_reg[FLAG_NOSYNC_BIT])
                        begin
                            push_data.pkt_class    = CLASS_NOSYNC;
                            push_data.sync_request = is_master;
                        end
                        else
                        begin
                            push_data.pkt_class = CLASS_DATA;
                        end
                        phase_next = (left_dec > FRAME_OVERHEAD) ? PH_LEN : PH_DISCARD;
                    end
                end

                PH_DISCARD:
                begin
                end

                default:
                begin
                end
            endcase
        end
    end

endmodule

### hw/rtl/rrfd_queue.sv
// Short word queue between the parser front end and the output stage.
// Depends on rrfd_pkg for the queued word and status types.
module rrfd_queue
    import rrfd_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rrfd_entry_t push_data,
    input  logic        pop,
    output rrfd_entry_t pop_data,
    output q_status_t   status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rrfd_entry_t      slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_data     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/rrfd_back.sv
// Output stage: pops classified words, forms the sync offset and holds the result register.
// Depends on rrfd_pkg and rrfd_out_if; fed by rrfd_queue.
module rrfd_back
    import rrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_status,
    input  rrfd_entry_t pop_data,
    output logic        pop,
    rrfd_out_if.source  out_ch
);

    logic        out_valid_reg, out_valid_next;
    rrfd_entry_t word_reg;
    logic [31:0] offset_reg;
    logic [31:0] offset_next;

    assign pop            = !q_status.empty && (!out_valid_reg || out_ch.ready);
    assign out_valid_next = pop ? 1'b1 : (out_valid_reg && !out_ch.ready);
    assign offset_next    = pop_data.sync_valid ? (pop_data.now_time - pop_data.stamp) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg   <= pop_data;
            offset_reg <= offset_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = word_reg.kind;
    assign out_ch.out_byte     = word_reg.out_byte;
    assign out_ch.stop_reason  = word_reg.reason;
    assign out_ch.pkt_len      = word_reg.pkt_len;
    assign out_ch.pkt_class    = word_reg.pkt_class;
    assign out_ch.rssi         = $signed(word_reg.rssi);
    assign out_ch.lqi          = word_reg.lqi;
    assign out_ch.sync_offset  = $signed(offset_reg);
    assign out_ch.sync_valid   = word_reg.sync_valid;
    assign out_ch.sync_request = word_reg.sync_request;
    assign out_ch.last         = (word_reg.kind != KIND_BYTE);

endmodule

### hw/rtl/radio_rx_fifo_deframer_unit.sv
// Receive FIFO deframer top level: one FIFO byte accepted per cycle while the queue is not full.
// A byte's result word is written into the queue and then into the output register.
// Throughput: one word per cycle while the output is ready; input stalls only when the QUEUE_DEPTH-word queue is full.
// Bytes that cause no result (length, RSSI, discarded bytes) are still accepted from the input.
// Reset (rst_n, asynchronous, active low) returns the parser to waiting for a length byte,
// empties the queue and output register, and sets max_payload_len to 120, is_master to 0.
module radio_rx_fifo_deframer_unit
    import rrfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    rrfd_in_if.sink     in_ch,
    rrfd_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "radio_rx_fifo_deframer_unit_macros.svh"

    // Configuration registers. They are to be written only while the block is idle,
    // so the parser may use them directly without any shadowing; the block does not enforce it.
    logic [7:0] max_payload_len_reg;
    logic       is_master_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_len_reg <= PAYLOAD_LIMIT_RESET;
            is_master_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MAX_PAYLOAD_LEN: max_payload_len_reg <= pwdata[7:0];
                REG_IS_MASTER:       is_master_reg       <= pwdata[0];
                default:             max_payload_len_reg <= max_payload_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_PAYLOAD_LEN: prdata = {24'd0, max_payload_len_reg};
            REG_IS_MASTER:       prdata = {31'd0, is_master_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // The front end classifies every accepted byte in its cycle and pushes at most
    // one word into the queue; the back end drains the queue into the output
    // register, forming the sync offset on the way. The queue lets the output
    // stall without stopping the input until it has filled.
    q_status_t   q_status;
    logic        q_push;
    logic        q_pop;
    rrfd_entry_t q_push_data;
    rrfd_entry_t q_pop_data;

    rrfd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .max_payload_len (max_payload_len_reg),
        .is_master       (is_master_reg),
        .q_status        (q_status),
        .push            (q_push),
        .push_data       (q_push_data)
    );

    rrfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    rrfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_data  (q_pop_data),
        .pop       (q_pop),
        .out_ch    (out_ch)
    );

    // A word is never pushed into a full queue.
    `RRFD_ASSERT_IMPL(a_no_overflow, clk, rst_n, q_push, !q_status.full)
    // A word popped from the queue is on the output in the next cycle.
    `RRFD_ASSERT_NEXT(a_pop_shows, clk, rst_n, q_pop, out_ch.valid)
    // Offset capture and sync requests belong to opposite node roles.
    `RRFD_ASSERT_IMPL(a_sync_roles, clk, rst_n, out_ch.valid,
                      !(out_ch.sync_valid && out_ch.sync_request))
    // Only a stop verdict carries a stop reason.
    `RRFD_ASSERT_IMPL(a_reason_kind, clk, rst_n,
                      out_ch.valid && (out_ch.stop_reason != REASON_NONE),
                      out_ch.kind == KIND_STOP)

endmodule
